@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the level meter color block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/lmgc_pkg.sv @@
// ----------------------------------------------------------------------------
// lmgc_pkg
// Types and constants of the level meter gradient color pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package lmgc_pkg;

	// Register indexes on the configuration port; the byte address is four times the index.
	localparam logic REG_OVER_POSITION = 1'b0;
	localparam logic REG_OVER_COLOR    = 1'b1;

	// Gradient parameter t: 16 fraction bits held in 17 bits so 1.0 is exact.
	localparam int T_W = 17;
	// Offset of t inside one segment; no segment is wider than 13107.
	localparam int X_W = 14;
	// Hue in degrees with 8 fraction bits.
	localparam int HUE_W = 16;
	// Scaled offset plus rounding term, and the reciprocal used to divide it.
	localparam int NUM_W = 28;
	localparam int RECIP_W = 29;
	localparam int RECIP_SH = 42;
	localparam int PROD_W = NUM_W + RECIP_W;

	localparam int NSTOPS = 7;
	localparam int NSEG = NSTOPS - 1;
	localparam int SEG_W = 3;

	// Hue curve stops.
	localparam logic [T_W-1:0] STOP_T [0:NSTOPS-1] = '{
		17'd0, 17'd13107, 17'd26214, 17'd36045, 17'd44564, 17'd53740, 17'd65536
	};
	localparam logic [7:0] STOP_HUE [0:NSTOPS-1] = '{
		8'd240, 8'd180, 8'd120, 8'd80, 8'd55, 8'd28, 8'd12
	};

	// Per segment: width in t, hue drop times 256, half width for rounding.
	localparam logic [X_W-1:0] SEG_DT [0:NSEG-1] = '{
		14'd13107, 14'd13107, 14'd9831, 14'd8519, 14'd9176, 14'd11796
	};
	localparam logic [X_W-1:0] SEG_DH [0:NSEG-1] = '{
		14'd15360, 14'd15360, 14'd10240, 14'd6400, 14'd6912, 14'd4096
	};
	localparam logic [X_W-1:0] SEG_HALF_DT [0:NSEG-1] = '{
		14'd6553, 14'd6553, 14'd4915, 14'd4259, 14'd4588, 14'd5898
	};

	// ceil(2^42 / width): exact floor division for numerators below 2^28.
	localparam logic [RECIP_W-1:0] SEG_RECIP [0:NSEG-1] = '{
		RECIP_W'(((64'd1 << RECIP_SH) + 64'd13106) / 64'd13107),
		RECIP_W'(((64'd1 << RECIP_SH) + 64'd13106) / 64'd13107),
		RECIP_W'(((64'd1 << RECIP_SH) + 64'd9830) / 64'd9831),
		RECIP_W'(((64'd1 << RECIP_SH) + 64'd8518) / 64'd8519),
		RECIP_W'(((64'd1 << RECIP_SH) + 64'd9175) / 64'd9176),
		RECIP_W'(((64'd1 << RECIP_SH) + 64'd11795) / 64'd11796)
	};

	// Word after the divider.
	typedef struct packed {
		logic           over;
		logic [T_W-1:0] t;
	} div_word_t;

	// Word after the hue curve.
	typedef struct packed {
		logic             over;
		logic [HUE_W-1:0] hue;
	} hue_word_t;

	// Result word.
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       is_over;
	} rgb_word_t;

endpackage

`default_nettype wire

@@ hdl/lmgc_divider.sv @@
// ----------------------------------------------------------------------------
// lmgc_divider
// Five-stage divider: t = floor(position * 2^16 / over_position) for t up to 1.0.
// ----------------------------------------------------------------------------
`default_nettype none

module lmgc_divider #(
	parameter int POS_BITS = 10
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [POS_BITS-1:0] position,
	input  wire logic [POS_BITS-1:0] over_position,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output lmgc_pkg::div_word_t      out_word
);
	import lmgc_pkg::*;

	localparam int DIV_STEPS = 4;

	typedef struct packed {
		logic                over;
		logic [POS_BITS-1:0] rem;
		logic [T_W-1:0]      quo;
	} div_st_t;

	// Four restoring division steps; a remainder below the divisor stays below it.
	function automatic div_st_t div_steps(input div_st_t cur, input logic [POS_BITS-1:0] d);
		div_st_t           nxt;
		logic [POS_BITS:0] r2;
		nxt = cur;
		for (int k = 0; k < DIV_STEPS; k++) begin
			r2 = {nxt.rem, 1'b0};
			if (r2 >= {1'b0, d}) begin
				nxt.rem = POS_BITS'(r2 - {1'b0, d});
				nxt.quo = {nxt.quo[T_W-2:0], 1'b1};
			end else begin
				nxt.rem = r2[POS_BITS-1:0];
				nxt.quo = {nxt.quo[T_W-2:0], 1'b0};
			end
		end
		return nxt;
	endfunction

	logic    v_s1, v_s2, v_s3, v_s4, v_s5;
	logic    rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;
	div_st_t st_in;
	div_st_t st_s1, st_s2, st_s3, st_s4, st_s5;

	// A stage takes a new word when it is empty or its word moves on.
	assign rdy_s5   = !v_s5 || out_ready;
	assign rdy_s4   = !v_s4 || rdy_s5;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// The integer quotient bit is set only when position equals the divisor.
	always_comb begin
		st_in      = '0;
		st_in.over = position > over_position;
		st_in.rem  = (position == over_position) ? '0 : position;
		st_in.quo  = {{(T_W-1){1'b0}}, (position == over_position)};
	end

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
		end
	end

	// Partial remainders and quotients; after the load, each stage adds four bits.
	always_ff @(posedge clk) begin
		if (rdy_s1) st_s1 <= st_in;
		if (rdy_s2) st_s2 <= div_steps(st_s1, over_position);
		if (rdy_s3) st_s3 <= div_steps(st_s2, over_position);
		if (rdy_s4) st_s4 <= div_steps(st_s3, over_position);
		if (rdy_s5) st_s5 <= div_steps(st_s4, over_position);
	end

	// A zero divisor gives t of zero.
	assign out_valid     = v_s5;
	assign out_word.over = st_s5.over;
	assign out_word.t    = (over_position == '0) ? '0 : st_s5.quo;

endmodule

`default_nettype wire

@@ hdl/lmgc_hue.sv @@
// ----------------------------------------------------------------------------
// lmgc_hue
// Four-stage piecewise-linear hue curve from t to hue in 1/256 degree.
// ----------------------------------------------------------------------------
`default_nettype none

module lmgc_hue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire lmgc_pkg::div_word_t  in_word,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output lmgc_pkg::hue_word_t       out_word
);
	import lmgc_pkg::*;

	logic              v_s6, v_s7, v_s8, v_s9;
	logic              rdy_s6, rdy_s7, rdy_s8, rdy_s9;
	logic [SEG_W-1:0]  seg_d;
	logic [X_W-1:0]    off_d;
	logic [NUM_W-1:0]  num_d;
	logic [PROD_W-1:0] prod_d;
	logic [HUE_W-1:0]  hue_d;

	logic              over_s6, over_s7, over_s8, over_s9;
	logic [SEG_W-1:0]  seg_s6, seg_s7, seg_s8;
	logic [X_W-1:0]    off_s6;
	logic [NUM_W-1:0]  num_s7;
	logic [X_W-1:0]    drop_s8;
	logic [HUE_W-1:0]  hue_s9;

	assign rdy_s9   = !v_s9 || out_ready;
	assign rdy_s8   = !v_s8 || rdy_s9;
	assign rdy_s7   = !v_s7 || rdy_s8;
	assign rdy_s6   = !v_s6 || rdy_s7;
	assign in_ready = rdy_s6;

	// Segment is the count of inner stops that t lies beyond.
	always_comb begin
		seg_d = '0;
		for (int k = 1; k < NSEG; k++) begin
			if (in_word.t > STOP_T[k]) seg_d = seg_d + SEG_W'(1);
		end
		off_d = X_W'(in_word.t - STOP_T[seg_d]);
	end

	// Offset times hue drop, plus half the segment width for rounding.
	assign num_d = NUM_W'(off_s6) * NUM_W'(SEG_DH[seg_s6]) + NUM_W'(SEG_HALF_DT[seg_s6]);

	// Division by the segment width as a multiply by its reciprocal.
	assign prod_d = PROD_W'(num_s7) * PROD_W'(SEG_RECIP[seg_s7]);

	// Hue falls from the segment's start hue.
	assign hue_d = {STOP_HUE[seg_s8], 8'd0} - HUE_W'(drop_s8);

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			if (rdy_s6) v_s6 <= in_valid;
			if (rdy_s7) v_s7 <= v_s6;
			if (rdy_s8) v_s8 <= v_s7;
			if (rdy_s9) v_s9 <= v_s8;
		end
	end

	// Payload stages.
	always_ff @(posedge clk) begin
		if (rdy_s6) begin
			over_s6 <= in_word.over;
			seg_s6  <= seg_d;
			off_s6  <= off_d;
		end
		if (rdy_s7) begin
			over_s7 <= over_s6;
			seg_s7  <= seg_s6;
			num_s7  <= num_d;
		end
		if (rdy_s8) begin
			over_s8 <= over_s7;
			seg_s8  <= seg_s7;
			drop_s8 <= prod_d[RECIP_SH +: X_W];
		end
		if (rdy_s9) begin
			over_s9 <= over_s8;
			hue_s9  <= hue_d;
		end
	end

	assign out_valid     = v_s9;
	assign out_word.over = over_s9;
	assign out_word.hue  = hue_s9;

endmodule

`default_nettype wire

@@ hdl/lmgc_rgb.sv @@
// ----------------------------------------------------------------------------
// lmgc_rgb
// Three-stage hue to RGB conversion at full saturation and value.
// ----------------------------------------------------------------------------
`default_nettype none

module lmgc_rgb (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire lmgc_pkg::hue_word_t in_word,
	input  wire logic [23:0]         over_color,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output lmgc_pkg::rgb_word_t      out_word
);
	import lmgc_pkg::*;

	localparam int HUE_SECTOR = 15360;
	localparam int NSECTOR = 4;
	localparam int SEC_W = 3;
	localparam int REM_W = 14;
	localparam int A_W = 22;
	localparam int V_W = A_W - 10;
	localparam int P_W = 25;
	// ceil(2^16 / 15): exact floor division by 15 for values below 4096.
	localparam logic [12:0] RECIP_15 = 13'(((1 << 16) + 14) / 15);

	localparam logic [SEC_W-1:0] SEC_RED_YELLOW  = 3'd0;
	localparam logic [SEC_W-1:0] SEC_YELLOW_GRN  = 3'd1;
	localparam logic [SEC_W-1:0] SEC_GRN_CYAN    = 3'd2;
	localparam logic [SEC_W-1:0] SEC_CYAN_BLUE   = 3'd3;

	logic             v_s10, v_s11, v_s12;
	logic             rdy_s10, rdy_s11, rdy_s12;
	logic [SEC_W-1:0] sector_d;
	logic [HUE_W-1:0] base_d;
	logic [REM_W-1:0] ramp_n;
	logic [A_W-1:0]   scaled;
	logic [P_W-1:0]   prod_d;
	logic [7:0]       ramp_x;
	rgb_word_t        word_d;

	logic             over_s10, over_s11;
	logic [SEC_W-1:0] sector_s10, sector_s11;
	logic [REM_W-1:0] rem_s10;
	logic [V_W-1:0]   v_part_s11;
	rgb_word_t        word_s12;

	assign rdy_s12  = !v_s12 || out_ready;
	assign rdy_s11  = !v_s11 || rdy_s12;
	assign rdy_s10  = !v_s10 || rdy_s11;
	assign in_ready = rdy_s10;

	// Sixty-degree sector and the remainder inside it.
	always_comb begin
		sector_d = '0;
		base_d   = '0;
		for (int k = 1; k <= NSECTOR; k++) begin
			if (in_word.hue >= HUE_W'(k * HUE_SECTOR)) begin
				sector_d = SEC_W'(k);
				base_d   = HUE_W'(k * HUE_SECTOR);
			end
		end
	end

	// Ramp rises in even sectors and falls in odd ones; scale by 255 and round.
	assign ramp_n = sector_s10[0] ? REM_W'(HUE_SECTOR - int'(rem_s10)) : rem_s10;
	assign scaled = A_W'(ramp_n) * A_W'(255) + A_W'(HUE_SECTOR / 2);

	// Remaining division by 15 through the reciprocal.
	assign prod_d = P_W'(v_part_s11) * P_W'(RECIP_15);
	assign ramp_x = prod_d[16 +: 8];

	// Channel selection by sector; the over color overrides all.
	always_comb begin
		word_d = '0;
		case (sector_s11)
			SEC_RED_YELLOW: begin
				word_d.red   = 8'hFF;
				word_d.green = ramp_x;
				word_d.blue  = 8'h00;
			end
			SEC_YELLOW_GRN: begin
				word_d.red   = ramp_x;
				word_d.green = 8'hFF;
				word_d.blue  = 8'h00;
			end
			SEC_GRN_CYAN: begin
				word_d.red   = 8'h00;
				word_d.green = 8'hFF;
				word_d.blue  = ramp_x;
			end
			SEC_CYAN_BLUE: begin
				word_d.red   = 8'h00;
				word_d.green = ramp_x;
				word_d.blue  = 8'hFF;
			end
			default: begin
				word_d.red   = ramp_x;
				word_d.green = 8'h00;
				word_d.blue  = 8'hFF;
			end
		endcase
		if (over_s11) begin
			word_d.red   = over_color[23:16];
			word_d.green = over_color[15:8];
			word_d.blue  = over_color[7:0];
		end
		word_d.is_over = over_s11;
	end

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
		end else begin
			if (rdy_s10) v_s10 <= in_valid;
			if (rdy_s11) v_s11 <= v_s10;
			if (rdy_s12) v_s12 <= v_s11;
		end
	end

	// Payload stages.
	always_ff @(posedge clk) begin
		if (rdy_s10) begin
			over_s10   <= in_word.over;
			sector_s10 <= sector_d;
			rem_s10    <= REM_W'(in_word.hue - base_d);
		end
		if (rdy_s11) begin
			over_s11   <= over_s10;
			sector_s11 <= sector_s10;
			v_part_s11 <= scaled[A_W-1:10];
		end
		if (rdy_s12) word_s12 <= word_d;
	end

	assign out_valid = v_s12;
	assign out_word  = word_s12;

endmodule

`default_nettype wire

@@ hdl/level_meter_gradient_color.sv @@
// ----------------------------------------------------------------------------
// level_meter_gradient_color
// Color of one level meter bar line from its position, on a hue gradient.
//
// Channel  Dir  Handshake                  Content
// item     in   item_valid / item_ready    position
// color    out  color_valid / color_ready  red, green, blue, is_over
// config   in   APB (psel .. pready)       over_position @0, over_color @4
//
// One word is taken per clock while item_ready is high; a result passes
// the 12 register stages in order: five for the division of
// position by over position, four for the hue curve, three for RGB.
// Reset clears the valid bits and loads the register defaults.
// A stall holds each full stage; empty stages still fill, so the input takes
// words until every stage is occupied.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module level_meter_gradient_color #(
	parameter int POS_BITS = 10
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// Configuration port.
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [2:0]          paddr,
	input  wire logic [31:0]         pwdata,
	output logic      [31:0]         prdata,
	output logic                     pready,
	// Position words.
	input  wire logic                item_valid,
	output logic                     item_ready,
	input  wire logic [POS_BITS-1:0] position,
	// Color words.
	output logic                     color_valid,
	input  wire logic                color_ready,
	output logic      [7:0]          red,
	output logic      [7:0]          green,
	output logic      [7:0]          blue,
	output logic                     is_over
);
	import lmgc_pkg::*;

	logic [POS_BITS-1:0] over_position_q;
	logic [23:0]         over_color_q;
	logic                reg_idx;

	logic      div_valid, div_ready;
	div_word_t div_word;
	logic      hue_valid, hue_ready;
	hue_word_t hue_word;
	rgb_word_t rgb_word;

	logic      out_stall;
	logic      over_out;
	logic      grad_out;
	logic      over_match;
	logic      grad_sat;

	assign pready  = 1'b1;
	assign reg_idx = paddr[2];

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			over_position_q <= POS_BITS'(10'd1023);
			over_color_q    <= 24'hDC0A05;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_OVER_POSITION: over_position_q <= pwdata[POS_BITS-1:0];
				REG_OVER_COLOR:    over_color_q    <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	// Register reads.
	always_comb begin
		case (reg_idx)
			REG_OVER_POSITION: prdata = 32'(over_position_q);
			REG_OVER_COLOR:    prdata = 32'(over_color_q);
			default:           prdata = '0;
		endcase
	end

	lmgc_divider #(
		.POS_BITS (POS_BITS)
	) u_divider (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (item_valid),
		.in_ready      (item_ready),
		.position      (position),
		.over_position (over_position_q),
		.out_valid     (div_valid),
		.out_ready     (div_ready),
		.out_word      (div_word)
	);

	lmgc_hue u_hue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_valid),
		.in_ready  (div_ready),
		.in_word   (div_word),
		.out_valid (hue_valid),
		.out_ready (hue_ready),
		.out_word  (hue_word)
	);

	lmgc_rgb u_rgb (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (hue_valid),
		.in_ready   (hue_ready),
		.in_word    (hue_word),
		.over_color (over_color_q),
		.out_valid  (color_valid),
		.out_ready  (color_ready),
		.out_word   (rgb_word)
	);

	assign red     = rgb_word.red;
	assign green   = rgb_word.green;
	assign blue    = rgb_word.blue;
	assign is_over = rgb_word.is_over;

	// Terms used by the checks below.
	assign out_stall  = color_valid && !color_ready;
	assign over_out   = color_valid && is_over;
	assign grad_out   = color_valid && !is_over;
	assign over_match = (red == over_color_q[23:16]) && (green == over_color_q[15:8])
		&& (blue == over_color_q[7:0]);
	assign grad_sat   = (red == 8'hFF || green == 8'hFF || blue == 8'hFF)
		&& (red == 8'h00 || green == 8'h00 || blue == 8'h00);

	// An over word carries the configured over color.
	`ASSERT_SAME_CYCLE(a_over_color, clk, arst_n, over_out, over_match, "over color wrong")

	// A gradient color is fully saturated: one channel at full, one at zero.
	`ASSERT_SAME_CYCLE(a_full_sat, clk, arst_n, grad_out, grad_sat, "gradient not saturated")

	// The input only stalls when the pipeline is full behind a waiting result.
	`ASSERT_SAME_CYCLE(a_stall_src, clk, arst_n, !item_ready, out_stall, "needless input stall")

	// A waiting result is still there in the next cycle.
	`ASSERT_NEXT_CYCLE(a_result_kept, clk, arst_n, out_stall, color_valid, "result dropped")

endmodule

`default_nettype wire
